>>> rtl/ps2_keyboard_controller_assert.svh
// Assertion macros shared by the checker.
`ifndef PS2_KEYBOARD_CONTROLLER_ASSERT_SVH
`define PS2_KEYBOARD_CONTROLLER_ASSERT_SVH

// Same-cycle implication, gated by reset.
`define PS2KC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2kc: same-cycle check failed");

// Next-cycle implication, gated by reset.
`define PS2KC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2kc: next-cycle check failed");

`endif

>>> rtl/ps2kc_pkg.sv
`timescale 1ns / 1ps
package ps2kc_pkg;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_DEVICE = 2'd2,
        OP_RESET  = 2'd3
    } ps2kc_op_t;

    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CMD  = 1'b1;

    localparam int RAM_DEPTH = 32;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // command groups, taken from bits 7:5
    localparam logic [2:0] GRP_RAM_READ  = 3'b001;
    localparam logic [2:0] GRP_RAM_WRITE = 3'b011;
    localparam logic [2:0] GRP_AX        = 3'b101;
    localparam logic [2:0] GRP_CX        = 3'b110;
    localparam logic [2:0] GRP_EX        = 3'b111;

    localparam logic [7:0] CMD_RAM0      = 8'h60;
    localparam logic [7:0] CMD_KBD_TEST2 = 8'ha4;
    localparam logic [7:0] CMD_AUX_DIS   = 8'ha7;
    localparam logic [7:0] CMD_AUX_EN    = 8'ha8;
    localparam logic [7:0] CMD_AUX_TEST  = 8'ha9;
    localparam logic [7:0] CMD_SELF_TEST = 8'haa;
    localparam logic [7:0] CMD_KBD_TEST  = 8'hab;
    localparam logic [7:0] CMD_KBD_DIS   = 8'had;
    localparam logic [7:0] CMD_KBD_EN    = 8'hae;
    localparam logic [7:0] CMD_READ_IN   = 8'hc0;
    localparam logic [7:0] CMD_POLL_LO   = 8'hc1;
    localparam logic [7:0] CMD_POLL_HI   = 8'hc2;
    localparam logic [7:0] CMD_READ_OUT  = 8'hd0;
    localparam logic [7:0] CMD_WRITE_OUT = 8'hd1;
    localparam logic [7:0] CMD_WRITE_KBD = 8'hd2;
    localparam logic [7:0] CMD_WRITE_AUX = 8'hd3;
    localparam logic [7:0] CMD_TO_AUX    = 8'hd4;
    localparam logic [7:0] CMD_RESET     = 8'hff;
    localparam logic [3:0] CMD_PULSE_HI  = 4'hf;

    localparam logic [7:0] ANS_PASSWD = 8'hf1;
    localparam logic [7:0] ANS_SELF   = 8'h55;
    localparam logic [7:0] ANS_OK     = 8'h00;

    typedef struct packed {
        ps2kc_op_t  operation;
        logic       port;
        logic [7:0] write_data;
    } ps2kc_req_t;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_data;
        logic [7:0] status_byte;
        logic [7:0] output_port;
        logic       reset_request;
    } ps2kc_rsp_t;

endpackage

>>> rtl/ps2kc_core.sv
`timescale 1ns / 1ps
module ps2kc_core
    import ps2kc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  ps2kc_req_t item,
    output ps2kc_rsp_t result
);

    logic [7:0]        status_reg, status_next;
    logic [7:0]        obuf_reg, obuf_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_cmd_reg, pend_cmd_next;
    logic [7:0]        oport_reg, oport_next;
    logic              rflag_reg, rflag_next;
    logic [7:0]        ram_reg [RAM_DEPTH];
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              rd_valid;
    logic [7:0]        rd_data;
    logic [7:0]        c;

    assign c = item.write_data;

    always_comb
    begin
        status_next     = status_reg;
        obuf_next       = obuf_reg;
        pend_valid_next = pend_valid_reg;
        pend_cmd_next   = pend_cmd_reg;
        oport_next      = oport_reg;
        rflag_next      = rflag_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_cmd_reg[RAM_AW-1:0];
        ram_wdata       = c;
        rd_valid        = 1'b0;
        rd_data         = 8'h00;

        case (item.operation)
            OP_READ:
            begin
                if (item.port == PORT_DATA)
                begin
                    if (status_reg[0])
                    begin
                        rd_valid       = 1'b1;
                        rd_data        = obuf_reg;
                        status_next[0] = 1'b0;
                    end
                end
                else
                begin
                    rd_valid = 1'b1;
                    rd_data  = status_reg;
                end
            end
            OP_WRITE:
            begin
                if (item.port == PORT_DATA)
                begin
                    status_next[3] = 1'b1;
                    if (pend_valid_reg)
                    begin
                        if (pend_cmd_reg[7:5] == GRP_RAM_WRITE)
                        begin
                            ram_we = 1'b1;
                            if (pend_cmd_reg == CMD_RAM0)
                                status_next[2] = c[2];
                        end
                        else if (pend_cmd_reg == CMD_WRITE_OUT)
                        begin
                            oport_next = c;
                            if (!c[0])
                                rflag_next = 1'b1;
                        end
                        else if (pend_cmd_reg == CMD_WRITE_KBD ||
                                 pend_cmd_reg == CMD_WRITE_AUX)
                        begin
                            obuf_next         = c;
                            status_next[0]    = 1'b1;
                            status_next[5]    = (pend_cmd_reg == CMD_WRITE_AUX);
                        end
                        pend_valid_next = 1'b0;
                        pend_cmd_next   = 8'h00;
                    end
                end
                else
                begin
                    status_next[3] = 1'b0;
                    case (c[7:5])
                        GRP_RAM_READ:
                        begin
                            obuf_next      = ram_reg[c[RAM_AW-1:0]];
                            status_next[5] = 1'b0;
                            status_next[0] = 1'b1;
                        end
                        GRP_RAM_WRITE:
                        begin
                            pend_valid_next = 1'b1;
                            pend_cmd_next   = c;
                        end
                        GRP_AX:
                        begin
                            case (c)
                                CMD_KBD_TEST2, CMD_AUX_TEST, CMD_SELF_TEST, CMD_KBD_TEST:
                                begin
                                    obuf_next      = (c == CMD_KBD_TEST2) ? ANS_PASSWD :
                                                     (c == CMD_SELF_TEST) ? ANS_SELF : ANS_OK;
                                    status_next[5] = 1'b0;
                                    status_next[0] = 1'b1;
                                end
                                CMD_AUX_DIS: status_next[5] = 1'b1;
                                CMD_AUX_EN:  status_next[5] = 1'b0;
                                CMD_KBD_DIS: status_next[4] = 1'b1;
                                CMD_KBD_EN:  status_next[4] = 1'b0;
                                default: ;
                            endcase
                        end
                        GRP_CX:
                        begin
                            // C0..C2 see the last written byte, which is the command itself
                            case (c)
                                CMD_READ_IN, CMD_READ_OUT:
                                begin
                                    obuf_next      = (c == CMD_READ_IN) ? c : oport_reg;
                                    status_next[5] = 1'b0;
                                    status_next[0] = 1'b1;
                                end
                                CMD_POLL_LO: status_next[7:4] = c[3:0];
                                CMD_POLL_HI: status_next[7:4] = c[7:4];
                                CMD_WRITE_OUT, CMD_WRITE_KBD, CMD_WRITE_AUX, CMD_TO_AUX:
                                begin
                                    pend_valid_next = 1'b1;
                                    pend_cmd_next   = c;
                                end
                                default: ;
                            endcase
                        end
                        GRP_EX:
                        begin
                            if (c == CMD_RESET)
                            begin
                                pend_valid_next  = 1'b0;
                                pend_cmd_next    = 8'h00;
                                rflag_next       = 1'b0;
                                status_next[1:0] = 2'b00;
                            end
                            else if (c[7:4] == CMD_PULSE_HI && !c[0])
                                rflag_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            OP_DEVICE:
            begin
                obuf_next      = c;
                status_next[5] = 1'b0;
                status_next[0] = 1'b1;
            end
            OP_RESET:
            begin
                pend_valid_next  = 1'b0;
                pend_cmd_next    = 8'h00;
                rflag_next       = 1'b0;
                status_next[1:0] = 2'b00;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= 8'h00;
            obuf_reg       <= 8'h00;
            pend_valid_reg <= 1'b0;
            pend_cmd_reg   <= 8'h00;
            oport_reg      <= 8'h00;
            rflag_reg      <= 1'b0;
            for (int i = 0; i < RAM_DEPTH; i++)
                ram_reg[i] <= 8'h00;
        end
        else if (step)
        begin
            status_reg     <= status_next;
            obuf_reg       <= obuf_next;
            pend_valid_reg <= pend_valid_next;
            pend_cmd_reg   <= pend_cmd_next;
            oport_reg      <= oport_next;
            rflag_reg      <= rflag_next;
            if (ram_we)
                ram_reg[ram_waddr] <= ram_wdata;
        end
    end

    assign result.read_valid    = rd_valid;
    assign result.read_data     = rd_data;
    assign result.status_byte   = status_next;
    assign result.output_port   = oport_next;
    assign result.reset_request = rflag_next;

endmodule

>>> rtl/ps2_keyboard_controller.sv
`timescale 1ns / 1ps
// 8042-style keyboard controller, host side.
// req channel (req_valid/req_ready/req): one word per bus access: a read,
// a write to port 60h or 64h, a byte from the keyboard, or a controller reset.
// rsp channel (rsp_valid/rsp_ready/rsp): exactly one word per request word,
// in order, carrying the read byte (if any), status, output port and the
// reset-request flag as they stand after that access.
// Path: the request word is captured in the input register, then the
// state update writes the response register, which drives rsp.
// Throughput: one word per cycle when not stalled; the state update is one
// register step, so back-to-back accesses see each other's effects.
// Reset: all controller state, including the 32-byte internal RAM, clears to
// zero and both channels come up empty; req_ready is high right after reset.
// Stall: while rsp_ready is low the response is held; one more request
// word is taken into the input register, then req_ready drops.
module ps2_keyboard_controller
    import ps2kc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  ps2kc_req_t req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output ps2kc_rsp_t rsp
);

    logic       s1_valid_reg, s1_valid_next;
    ps2kc_req_t s1_word_reg;
    logic       out_valid_reg, out_valid_next;
    ps2kc_rsp_t out_word_reg;
    ps2kc_rsp_t core_rsp;
    logic       advance;
    logic       s1_fire;

    assign advance   = !out_valid_reg || rsp_ready;
    assign s1_fire   = s1_valid_reg && advance;
    assign req_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next  = req_ready ? req_valid : s1_valid_reg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            s1_word_reg <= req;
        if (s1_fire)
            out_word_reg <= core_rsp;
    end

    ps2kc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_fire),
        .item   (s1_word_reg),
        .result (core_rsp)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

endmodule

>>> rtl/ps2kc_checker.sv
`timescale 1ns / 1ps
`include "ps2_keyboard_controller_assert.svh"
module ps2kc_checker
    import ps2kc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input ps2kc_req_t req,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input ps2kc_rsp_t rsp
);

    `PS2KC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
    `PS2KC_ASSERT_NOW(a_rd_zero, clk, rst_n, rsp_valid && !rsp.read_valid, rsp.read_data == 8'h00)
    `PS2KC_ASSERT_NOW(a_st_bit1, clk, rst_n, rsp_valid, !rsp.status_byte[1])
    `PS2KC_ASSERT_NOW(a_decouple, clk, rst_n, !rsp_valid, req_ready)

endmodule

bind ps2_keyboard_controller ps2kc_checker u_ps2kc_checker (.*);

>>> tb/kbc_response_checker.sv
`timescale 1ns / 1ps
module kbc_response_checker
    import ps2kc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_ready,
    input  ps2kc_req_t req,
    input  logic       rsp_valid,
    input  logic       rsp_ready,
    input  ps2kc_rsp_t rsp,
    output int         fail_count,
    output int         n_expected
);

    localparam int ST_OBF     = 0;
    localparam int ST_SYS     = 2;
    localparam int ST_CMD     = 3;
    localparam int ST_KBD_DIS = 4;
    localparam int ST_AUX     = 5;

    logic [7:0] sts;
    logic [7:0] obuf;
    logic [7:0] last_wr;
    logic       cmd_armed;
    logic [7:0] armed_cmd;
    logic [7:0] ram [RAM_DEPTH];
    logic [7:0] oport;
    logic       rst_req;

    ps2kc_rsp_t expected_rsp_q[$];
    ps2kc_rsp_t want;

    function automatic void fill_obuf(input logic [7:0] v);
        obuf = v;
        sts[ST_AUX] = 1'b0;
        sts[ST_OBF] = 1'b1;
    endfunction

    function automatic void kbc_soft_reset();
        cmd_armed = 1'b0;
        armed_cmd = '0;
        rst_req = 1'b0;
        sts[1:0] = 2'b00;
    endfunction

    // Applies one bus access to the controller state and returns the
    // word the block should answer with.
    function automatic ps2kc_rsp_t kbc_access(input ps2kc_req_t w);
        ps2kc_rsp_t r;
        logic [7:0] v;
        r = '0;
        v = w.write_data;
        case (w.operation)
            OP_READ:
            begin
                if (w.port == PORT_DATA)
                begin
                    if (sts[ST_OBF])
                    begin
                        r.read_valid = 1'b1;
                        r.read_data = obuf;
                        sts[ST_OBF] = 1'b0;
                    end
                end
                else
                begin
                    r.read_valid = 1'b1;
                    r.read_data = sts;
                end
            end
            OP_WRITE:
            begin
                last_wr = v;
                if (w.port == PORT_DATA)
                begin
                    sts[ST_CMD] = 1'b1;
                    if (cmd_armed)
                    begin
                        if (armed_cmd[7:5] == GRP_RAM_WRITE)
                        begin
                            ram[armed_cmd[4:0]] = v;
                            if (armed_cmd == CMD_RAM0)
                                sts[ST_SYS] = v[2];
                        end
                        else if (armed_cmd == CMD_WRITE_OUT)
                        begin
                            oport = v;
                            if (!v[0])
                                rst_req = 1'b1;
                        end
                        else if (armed_cmd == CMD_WRITE_KBD)
                            fill_obuf(v);
                        else if (armed_cmd == CMD_WRITE_AUX)
                        begin
                            fill_obuf(v);
                            sts[ST_AUX] = 1'b1;
                        end
                        cmd_armed = 1'b0;
                        armed_cmd = '0;
                    end
                end
                else
                begin
                    sts[ST_CMD] = 1'b0;
                    case (v[7:5])
                        GRP_RAM_READ:
                            fill_obuf(ram[v[4:0]]);
                        GRP_RAM_WRITE:
                        begin
                            cmd_armed = 1'b1;
                            armed_cmd = v;
                        end
                        GRP_AX:
                        begin
                            case (v)
                                CMD_KBD_TEST2: fill_obuf(ANS_PASSWD);
                                CMD_AUX_DIS:   sts[ST_AUX] = 1'b1;
                                CMD_AUX_EN:    sts[ST_AUX] = 1'b0;
                                CMD_AUX_TEST:  fill_obuf(ANS_OK);
                                CMD_SELF_TEST: fill_obuf(ANS_SELF);
                                CMD_KBD_TEST:  fill_obuf(ANS_OK);
                                CMD_KBD_DIS:   sts[ST_KBD_DIS] = 1'b1;
                                CMD_KBD_EN:    sts[ST_KBD_DIS] = 1'b0;
                                default:       ;
                            endcase
                        end
                        GRP_CX:
                        begin
                            case (v)
                                CMD_READ_IN:  fill_obuf(last_wr);
                                CMD_POLL_LO:  sts = {last_wr[3:0], sts[3:0]};
                                CMD_POLL_HI:  sts = {last_wr[7:4], sts[3:0]};
                                CMD_READ_OUT: fill_obuf(oport);
                                CMD_WRITE_OUT, CMD_WRITE_KBD, CMD_WRITE_AUX, CMD_TO_AUX:
                                begin
                                    cmd_armed = 1'b1;
                                    armed_cmd = v;
                                end
                                default: ;
                            endcase
                        end
                        GRP_EX:
                        begin
                            if (v == CMD_RESET)
                                kbc_soft_reset();
                            else if (v[7:4] == CMD_PULSE_HI && !v[0])
                                rst_req = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            OP_DEVICE:
                fill_obuf(v);
            default:
                kbc_soft_reset();
        endcase
        r.status_byte = sts;
        r.output_port = oport;
        r.reset_request = rst_req;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sts = '0;
            obuf = '0;
            last_wr = '0;
            cmd_armed = 1'b0;
            armed_cmd = '0;
            foreach (ram[i])
                ram[i] = '0;
            oport = '0;
            rst_req = 1'b0;
            expected_rsp_q.delete();
            n_expected <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_rsp_q.push_back(kbc_access(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("ERROR %0t: unexpected rsp word rv=%0b rd=%02h st=%02h op=%02h rr=%0b",
                                 $time, rsp.read_valid, rsp.read_data, rsp.status_byte,
                                 rsp.output_port, rsp.reset_request);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.read_valid !== want.read_valid ||
                        rsp.read_data !== want.read_data ||
                        rsp.status_byte !== want.status_byte ||
                        rsp.output_port !== want.output_port ||
                        rsp.reset_request !== want.reset_request)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("ERROR %0t: rsp exp rv=%0b rd=%02h st=%02h op=%02h rr=%0b got rv=%0b rd=%02h st=%02h op=%02h rr=%0b",
                                     $time, want.read_valid, want.read_data, want.status_byte,
                                     want.output_port, want.reset_request,
                                     rsp.read_valid, rsp.read_data, rsp.status_byte,
                                     rsp.output_port, rsp.reset_request);
                    end
                end
            end
            n_expected <= expected_rsp_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ps2kc_pkg::*;

    localparam int ITEMS_PER_PHASE = 310;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    ps2kc_req_t req = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    ps2kc_rsp_t rsp;

    int send_idle = 0;
    int rcv_idle = 0;
    int fail_count;
    int n_expected;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    ps2_keyboard_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    kbc_response_checker u_rsp_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .n_expected (n_expected)
    );

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic ps2kc_req_t mk(input ps2kc_op_t o, input logic p,
                                      input logic [7:0] d);
        ps2kc_req_t w;
        w.operation = o;
        w.port = p;
        w.write_data = d;
        return w;
    endfunction

    function automatic logic [7:0] pick_command();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        case ($urandom_range(9))
            0: c = {GRP_RAM_READ, c[4:0]};
            1, 2: c = ($urandom_range(3) == 0) ? CMD_RAM0 : {GRP_RAM_WRITE, c[4:0]};
            3:
            begin
                case ($urandom_range(8))
                    0: c = CMD_KBD_TEST2;
                    1: c = CMD_AUX_DIS;
                    2: c = CMD_AUX_EN;
                    3: c = CMD_AUX_TEST;
                    4: c = CMD_SELF_TEST;
                    5: c = CMD_KBD_TEST;
                    6: c = CMD_KBD_DIS;
                    7: c = CMD_KBD_EN;
                    default: c = {GRP_AX, c[4:0]};
                endcase
            end
            4:
            begin
                case ($urandom_range(3))
                    0: c = CMD_READ_IN;
                    1: c = CMD_POLL_LO;
                    2: c = CMD_POLL_HI;
                    default: c = CMD_READ_OUT;
                endcase
            end
            5, 6:
            begin
                case ($urandom_range(3))
                    0: c = CMD_WRITE_OUT;
                    1: c = CMD_WRITE_KBD;
                    2: c = CMD_WRITE_AUX;
                    default: c = CMD_TO_AUX;
                endcase
            end
            7: c = {CMD_PULSE_HI, c[3:0]};
            8: c = CMD_RESET;
            default: ;
        endcase
        return c;
    endfunction

    function automatic ps2kc_req_t rand_word();
        ps2kc_req_t w;
        int k;
        w.port = 1'($urandom_range(1));
        w.write_data = 8'($urandom_range(255));
        k = $urandom_range(99);
        if (k < 22)
        begin
            w.operation = OP_READ;
            w.port = (k < 15) ? PORT_DATA : PORT_CMD;
        end
        else if (k < 52)
        begin
            w.operation = OP_WRITE;
            w.port = PORT_CMD;
            w.write_data = pick_command();
        end
        else if (k < 77)
        begin
            w.operation = OP_WRITE;
            w.port = PORT_DATA;
        end
        else if (k < 95)
            w.operation = OP_DEVICE;
        else
            w.operation = OP_RESET;
        return w;
    endfunction

    task automatic send_word(input ps2kc_req_t w);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (n_expected != 0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(mk(OP_READ,   PORT_CMD,  8'h5a));
        send_word(mk(OP_READ,   PORT_DATA, 8'ha5));
        send_word(mk(OP_DEVICE, PORT_CMD,  8'hff));
        send_word(mk(OP_READ,   PORT_DATA, 8'h00));
        send_word(mk(OP_WRITE,  PORT_CMD,  CMD_RAM0));
        send_word(mk(OP_WRITE,  PORT_DATA, 8'hff));
        send_word(mk(OP_WRITE,  PORT_CMD,  {GRP_RAM_READ, 5'd0}));
        send_word(mk(OP_READ,   PORT_DATA, 8'h00));
        send_word(mk(OP_WRITE,  PORT_CMD,  CMD_WRITE_OUT));
        send_word(mk(OP_WRITE,  PORT_DATA, 8'h00));
        send_word(mk(OP_WRITE,  PORT_CMD,  CMD_READ_OUT));
        send_word(mk(OP_WRITE,  PORT_CMD,  8'hf0));
        send_word(mk(OP_WRITE,  PORT_CMD,  CMD_RESET));
        send_word(mk(OP_WRITE,  PORT_CMD,  CMD_KBD_TEST2));
        send_word(mk(OP_WRITE,  PORT_CMD,  CMD_AUX_DIS));
        send_word(mk(OP_WRITE,  PORT_CMD,  CMD_KBD_DIS));
        send_word(mk(OP_WRITE,  PORT_CMD,  CMD_POLL_LO));
        send_word(mk(OP_WRITE,  PORT_CMD,  CMD_POLL_HI));
        send_word(mk(OP_WRITE,  PORT_CMD,  CMD_WRITE_AUX));
        send_word(mk(OP_WRITE,  PORT_DATA, 8'h5a));
        send_word(mk(OP_WRITE,  PORT_CMD,  CMD_TO_AUX));
        send_word(mk(OP_WRITE,  PORT_DATA, 8'h33));
        send_word(mk(OP_RESET,  PORT_CMD,  8'hff));
        send_word(mk(OP_WRITE,  PORT_DATA, 8'h00));
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: begin send_idle = 37; rcv_idle = 70; end
                1: begin send_idle = 70; rcv_idle = 37; end
                default: begin send_idle = 0; rcv_idle = 0; end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_word(rand_word());
            drain();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
